// ===== design/tslp_pkg.sv =====
// Package for the text sample line parser.
// Holds status and phase codes, character constants and the shared structs.
// No dependencies.
package tslp_pkg;

	// Result status codes; the line kind reuses the same encoding
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD     = 3'd1,
		ST_FLUSH   = 3'd2,
		ST_COMMENT = 3'd3,
		ST_OTHER   = 3'd4,
		ST_UNKNOWN = 3'd5,
		ST_EMPTY   = 3'd6
	} status_t;

	// A sample line carries the same code as a good sample
	localparam status_t KIND_SAMPLE = ST_OK;

	// Position in the sample grammar "s=x,y,a,b,c,i"
	typedef enum logic [3:0] {
		PH_START   = 4'd0,
		PH_EQUALS  = 4'd1,
		PH_FIELD_X = 4'd2,
		PH_FIELD_Y = 4'd3,
		PH_FIELD_A = 4'd4,
		PH_FIELD_B = 4'd5,
		PH_FLAG_C  = 4'd6,
		PH_COMMA_I = 4'd7,
		PH_FLAG_I  = 4'd8,
		PH_DONE    = 4'd9
	} phase_t;

	localparam logic [3:0] MIN_SAMPLE_LEN = 4'd14;

	// ASCII codes the parser looks for
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_P      = 8'h70;

	// Register reset values
	localparam logic [15:0] DAC_MAX_RESET        = 16'd4095;
	localparam logic [12:0] PACKET_SAMPLES_RESET = 13'd64;

	typedef struct packed {
		logic [15:0] dac_max;
		logic [12:0] packet_samples;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] coord_x;
		logic [15:0] coord_y;
		logic [11:0] level_a;
		logic [15:0] level_b;
		logic        flag_c;
		logic        flag_interlock;
		logic        packet_end;
		logic [11:0] pending_count;
	} result_t;

endpackage

// ===== design/tslp_if.sv =====
// Valid/ready channel interfaces for characters in and line results out.
// Plain signals only; no package dependency.
interface tslp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       line_end;

	modport source (output valid, output char_code, output line_end, input ready);
	modport sink (input valid, input char_code, input line_end, output ready);
endinterface

interface tslp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] coord_x;
	logic [15:0] coord_y;
	logic [11:0] level_a;
	logic [15:0] level_b;
	logic        flag_c;
	logic        flag_interlock;
	logic        packet_end;
	logic [11:0] pending_count;

	modport source (output valid, output status, output coord_x, output coord_y,
		output level_a, output level_b, output flag_c, output flag_interlock,
		output packet_end, output pending_count, input ready);
	modport sink (input valid, input status, input coord_x, input coord_y,
		input level_a, input level_b, input flag_c, input flag_interlock,
		input packet_end, input pending_count, output ready);
endinterface

// ===== design/tslp_cfg_regs.sv =====
// APB-style configuration registers: dac_max at 0x0, packet_samples at 0x4.
// Depends on tslp_pkg.
module tslp_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output tslp_pkg::cfg_t      cfg
);

	localparam logic REG_DAC_MAX        = 1'b0;
	localparam logic REG_PACKET_SAMPLES = 1'b1;

	tslp_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes, decoded on the word address bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dac_max        <= tslp_pkg::DAC_MAX_RESET;
			cfg_q.packet_samples <= tslp_pkg::PACKET_SAMPLES_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_DAC_MAX:        cfg_q.dac_max        <= pwdata[15:0];
				REG_PACKET_SAMPLES: cfg_q.packet_samples <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (paddr[2])
			REG_DAC_MAX:        prdata = {16'd0, cfg_q.dac_max};
			REG_PACKET_SAMPLES: prdata = {19'd0, cfg_q.packet_samples};
			default:            prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== design/tslp_line_core.sv =====
// Per-line parse state and result computation, one character per step.
// Depends on tslp_pkg.
module tslp_line_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          char_code,
	input  logic                line_end,
	input  tslp_pkg::cfg_t      cfg,
	output tslp_pkg::result_t   result
);

	// Line state
	logic [3:0]        char_count_q;
	tslp_pkg::phase_t  phase_q;
	logic [19:0]       acc_q;
	logic              digit_seen_q;
	logic [15:0]       held_x_q, held_y_q, held_b_q;
	logic [11:0]       held_a_q;
	logic              held_c_q, held_i_q;
	logic              line_error_q;
	tslp_pkg::status_t line_kind_q;
	logic [11:0]       sample_counter_q;

	// Next values
	logic [3:0]        char_count_d;
	tslp_pkg::phase_t  phase_d;
	logic [19:0]       acc_d;
	logic              digit_seen_d;
	logic [15:0]       held_x_d, held_y_d, held_b_d;
	logic [11:0]       held_a_d;
	logic              held_c_d, held_i_d;
	logic              line_error_d;
	tslp_pkg::status_t line_kind_d;
	logic [11:0]       sample_counter_d;

	logic              is_digit;
	logic              is_flag;
	logic [7:0]        ch_off;
	logic [19:0]       acc_digit;
	logic [12:0]       count_inc;

	assign is_digit  = (char_code >= tslp_pkg::CH_ZERO) && (char_code <= tslp_pkg::CH_NINE);
	assign is_flag   = (char_code == tslp_pkg::CH_ZERO) || (char_code == tslp_pkg::CH_ONE);
	assign ch_off    = char_code - tslp_pkg::CH_ZERO;
	// acc stays at or below dac_max while parsing runs, so times ten fits 20 bits
	assign acc_digit = (acc_q << 3) + (acc_q << 1) + {16'd0, ch_off[3:0]};
	assign count_inc = {1'b0, sample_counter_q} + 13'd1;

	always_comb begin
		char_count_d     = char_count_q;
		phase_d          = phase_q;
		acc_d            = acc_q;
		digit_seen_d     = digit_seen_q;
		held_x_d         = held_x_q;
		held_y_d         = held_y_q;
		held_a_d         = held_a_q;
		held_b_d         = held_b_q;
		held_c_d         = held_c_q;
		held_i_d         = held_i_q;
		line_error_d     = line_error_q;
		line_kind_d      = line_kind_q;
		sample_counter_d = sample_counter_q;
		result           = '0;
		result.status    = tslp_pkg::ST_EMPTY;

		// First character picks the line kind; later ones feed the sample grammar
		if (char_count_q == 4'd0) begin
			if (char_code == tslp_pkg::CH_S) begin
				line_kind_d = tslp_pkg::KIND_SAMPLE;
				phase_d     = tslp_pkg::PH_EQUALS;
			end else if (char_code == tslp_pkg::CH_F) begin
				line_kind_d = tslp_pkg::ST_FLUSH;
			end else if (char_code == tslp_pkg::CH_HASH) begin
				line_kind_d = tslp_pkg::ST_COMMENT;
			end else if (char_code == tslp_pkg::CH_R || char_code == tslp_pkg::CH_E ||
				char_code == tslp_pkg::CH_P) begin
				line_kind_d = tslp_pkg::ST_OTHER;
			end else begin
				line_kind_d = tslp_pkg::ST_UNKNOWN;
			end
		end else if (line_kind_q == tslp_pkg::KIND_SAMPLE && !line_error_q &&
			phase_q != tslp_pkg::PH_DONE) begin
			case (phase_q)
				tslp_pkg::PH_EQUALS: begin
					if (char_code == tslp_pkg::CH_EQUALS) phase_d = tslp_pkg::PH_FIELD_X;
					else line_error_d = 1'b1;
				end
				tslp_pkg::PH_FIELD_X, tslp_pkg::PH_FIELD_Y,
				tslp_pkg::PH_FIELD_A, tslp_pkg::PH_FIELD_B: begin
					if (is_digit) begin
						acc_d        = acc_digit;
						digit_seen_d = 1'b1;
						if (acc_digit > {4'd0, cfg.dac_max}) line_error_d = 1'b1;
					end else if (digit_seen_q && char_code == tslp_pkg::CH_COMMA) begin
						case (phase_q)
							tslp_pkg::PH_FIELD_X: held_x_d = acc_q[15:0];
							tslp_pkg::PH_FIELD_Y: held_y_d = acc_q[15:0];
							tslp_pkg::PH_FIELD_A: held_a_d = acc_q[11:0];
							default:              held_b_d = acc_q[15:0];
						endcase
						acc_d        = '0;
						digit_seen_d = 1'b0;
						phase_d      = tslp_pkg::phase_t'(phase_q + 4'd1);
					end else begin
						line_error_d = 1'b1;
					end
				end
				tslp_pkg::PH_FLAG_C: begin
					if (is_flag) begin
						held_c_d = char_code[0];
						phase_d  = tslp_pkg::PH_COMMA_I;
					end else begin
						line_error_d = 1'b1;
					end
				end
				tslp_pkg::PH_COMMA_I: begin
					if (char_code == tslp_pkg::CH_COMMA) phase_d = tslp_pkg::PH_FLAG_I;
					else line_error_d = 1'b1;
				end
				tslp_pkg::PH_FLAG_I: begin
					if (is_flag) begin
						held_i_d = char_code[0];
						phase_d  = tslp_pkg::PH_DONE;
					end else begin
						line_error_d = 1'b1;
					end
				end
				default: line_error_d = 1'b1;
			endcase
		end

		// Length counter saturates at the minimum sample length
		if (char_count_q < tslp_pkg::MIN_SAMPLE_LEN) char_count_d = char_count_q + 4'd1;

		// Line end: build the result, then clear the line state
		if (line_end) begin
			if (char_count_d < 4'd2) begin
				result.status = tslp_pkg::ST_EMPTY;
			end else if (line_kind_d == tslp_pkg::KIND_SAMPLE) begin
				if (!line_error_d && phase_d == tslp_pkg::PH_DONE &&
					char_count_d >= tslp_pkg::MIN_SAMPLE_LEN) begin
					result.status         = tslp_pkg::ST_OK;
					result.coord_x        = held_x_d;
					result.coord_y        = held_y_d;
					result.level_a        = held_a_d;
					result.level_b        = held_b_d;
					result.flag_c         = held_c_d;
					result.flag_interlock = held_i_d;
					if (count_inc == cfg.packet_samples) begin
						sample_counter_d  = '0;
						result.packet_end = 1'b1;
					end else begin
						sample_counter_d  = count_inc[11:0];
					end
				end else begin
					result.status = tslp_pkg::ST_BAD;
				end
			end else if (line_kind_d == tslp_pkg::ST_FLUSH) begin
				result.status        = tslp_pkg::ST_FLUSH;
				result.pending_count = sample_counter_q;
				sample_counter_d     = '0;
			end else begin
				result.status = line_kind_d;
			end

			char_count_d = '0;
			phase_d      = tslp_pkg::PH_START;
			acc_d        = '0;
			digit_seen_d = 1'b0;
			held_x_d     = '0;
			held_y_d     = '0;
			held_a_d     = '0;
			held_b_d     = '0;
			held_c_d     = 1'b0;
			held_i_d     = 1'b0;
			line_error_d = 1'b0;
			line_kind_d  = tslp_pkg::KIND_SAMPLE;
		end
	end

	// State registers, updated once per character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q     <= '0;
			phase_q          <= tslp_pkg::PH_START;
			acc_q            <= '0;
			digit_seen_q     <= 1'b0;
			held_x_q         <= '0;
			held_y_q         <= '0;
			held_a_q         <= '0;
			held_b_q         <= '0;
			held_c_q         <= 1'b0;
			held_i_q         <= 1'b0;
			line_error_q     <= 1'b0;
			line_kind_q      <= tslp_pkg::KIND_SAMPLE;
			sample_counter_q <= '0;
		end else if (step_en) begin
			char_count_q     <= char_count_d;
			phase_q          <= phase_d;
			acc_q            <= acc_d;
			digit_seen_q     <= digit_seen_d;
			held_x_q         <= held_x_d;
			held_y_q         <= held_y_d;
			held_a_q         <= held_a_d;
			held_b_q         <= held_b_d;
			held_c_q         <= held_c_d;
			held_i_q         <= held_i_d;
			line_error_q     <= line_error_d;
			line_kind_q      <= line_kind_d;
			sample_counter_q <= sample_counter_d;
		end
	end

endmodule

// ===== design/text_sample_line_parser.sv =====
// Text sample line parser, top level.
// Depends on tslp_pkg, tslp_if, tslp_cfg_regs and tslp_line_core.
//
// Characters of a command line arrive on in_chan one request at a time, with
// line_end high on the last one. Sample lines "s=x,y,a,b,c,i" are checked
// and parsed; every line yields exactly one result request on out_chan, on
// its last character. Other characters yield nothing.
// Throughput: one character per cycle. Each character is held in the input
// register; the parse state update and the result are computed from it in
// the same cycle and loaded into the output register when the character
// advances; the result is then offered from the output register.
// When out_chan stalls, characters that end no line still flow through; a
// line_end character waits in the input register until the pending result
// is taken, and in_chan ready drops then.
// Reset clears the line state, the sample counter and both registers' valid
// flags, and loads dac_max = 4095 and packet_samples = 64. The user must write
// registers over the APB port while the block is idle; it does not enforce this.
module text_sample_line_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	tslp_char_if.sink             in_chan,
	tslp_result_if.source         out_chan
);

	tslp_pkg::cfg_t    cfg;
	tslp_pkg::result_t core_result;
	tslp_pkg::result_t result_q;
	logic              result_valid_q;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              last_s1;
	logic              advance;

	tslp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The held character moves on unless it ends a line and the result slot is blocked
	assign advance       = valid_s1 && (!last_s1 || !result_valid_q || out_chan.ready);
	assign in_chan.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.valid && in_chan.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_chan.valid && in_chan.ready) begin
			char_s1 <= in_chan.char_code;
			last_s1 <= in_chan.line_end;
		end
	end

	tslp_line_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.char_code (char_s1),
		.line_end  (last_s1),
		.cfg       (cfg),
		.result    (core_result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (out_chan.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= core_result;
		end
	end

	assign out_chan.valid          = result_valid_q;
	assign out_chan.status         = result_q.status;
	assign out_chan.coord_x        = result_q.coord_x;
	assign out_chan.coord_y        = result_q.coord_y;
	assign out_chan.level_a        = result_q.level_a;
	assign out_chan.level_b        = result_q.level_b;
	assign out_chan.flag_c         = result_q.flag_c;
	assign out_chan.flag_interlock = result_q.flag_interlock;
	assign out_chan.packet_end     = result_q.packet_end;
	assign out_chan.pending_count  = result_q.pending_count;

endmodule

// ===== verif/tslp_tb_pkg.sv =====
`timescale 1ns / 1ps
// Testbench-side constants for the text sample line parser: register addresses.
// Shared by the line checker and the testbench top; no dependencies.
package tslp_tb_pkg;

	// Byte addresses of the configuration registers on the APB port
	typedef enum logic [2:0] {
		ADDR_DAC_MAX        = 3'd0,
		ADDR_PACKET_SAMPLES = 3'd4
	} reg_addr_t;

endpackage

// ===== verif/tslp_line_checker.sv =====
`timescale 1ns / 1ps
// Line-result checker for the text sample line parser: follows APB writes and
// character requests, predicts each line's result and compares it field by field.
// Depends on tslp_pkg, tslp_tb_pkg and the tslp_if interfaces.
module tslp_line_checker
	import tslp_pkg::*;
	import tslp_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	tslp_char_if        chars,
	tslp_result_if      results,
	output int          mismatches,
	output int          outstanding,
	output int          results_checked
);

	// Register copies
	logic [15:0] dac_max;
	logic [12:0] packet_len;

	// Line state of the predictor
	status_t     kind;
	phase_t      ph;
	logic [3:0]  len_cnt;
	logic [19:0] acc;
	logic        got_digit;
	logic        bad;
	logic [15:0] fld_x, fld_y, fld_b;
	logic [11:0] fld_a;
	logic        fld_c, fld_i;
	logic [11:0] in_packet;

	result_t     line_results_q[$];
	result_t     want;
	result_t     predicted;

	function automatic void clear_line();
		kind      = KIND_SAMPLE;
		ph        = PH_START;
		len_cnt   = '0;
		acc       = '0;
		got_digit = 1'b0;
		bad       = 1'b0;
		fld_x     = '0;
		fld_y     = '0;
		fld_a     = '0;
		fld_b     = '0;
		fld_c     = 1'b0;
		fld_i     = 1'b0;
	endfunction

	// One character of a sample line after its leading 's'
	function automatic void parse_sample_char(input logic [7:0] ch);
		logic is_digit;
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		if (bad || ph == PH_DONE)
			return;
		case (ph)
			PH_EQUALS: begin
				if (ch == CH_EQUALS) ph = PH_FIELD_X;
				else bad = 1'b1;
			end
			PH_FIELD_X, PH_FIELD_Y, PH_FIELD_A, PH_FIELD_B: begin
				if (is_digit) begin
					acc = acc * 20'd10 + 20'(ch - CH_ZERO);
					got_digit = 1'b1;
					if (acc > dac_max) bad = 1'b1;
				end else if (got_digit && ch == CH_COMMA) begin
					case (ph)
						PH_FIELD_X: fld_x = acc[15:0];
						PH_FIELD_Y: fld_y = acc[15:0];
						PH_FIELD_A: fld_a = acc[11:0];
						default:    fld_b = acc[15:0];
					endcase
					acc = '0;
					got_digit = 1'b0;
					ph = phase_t'(ph + 4'd1);
				end else begin
					bad = 1'b1;
				end
			end
			PH_FLAG_C: begin
				if (ch == CH_ZERO || ch == CH_ONE) begin
					fld_c = ch[0];
					ph = PH_COMMA_I;
				end else begin
					bad = 1'b1;
				end
			end
			PH_COMMA_I: begin
				if (ch == CH_COMMA) ph = PH_FLAG_I;
				else bad = 1'b1;
			end
			PH_FLAG_I: begin
				if (ch == CH_ZERO || ch == CH_ONE) begin
					fld_i = ch[0];
					ph = PH_DONE;
				end else begin
					bad = 1'b1;
				end
			end
			default: bad = 1'b1;
		endcase
	endfunction

	// Advance by one character; returns 1 with the line result on the last one
	function automatic bit predict_char(input logic [7:0] ch, input logic last,
			output result_t r);
		logic [12:0] next_cnt;
		r = '0;
		if (len_cnt == 4'd0) begin
			if (ch == CH_S) begin
				kind = KIND_SAMPLE;
				ph = PH_EQUALS;
			end else if (ch == CH_F) begin
				kind = ST_FLUSH;
			end else if (ch == CH_HASH) begin
				kind = ST_COMMENT;
			end else if (ch == CH_R || ch == CH_E || ch == CH_P) begin
				kind = ST_OTHER;
			end else begin
				kind = ST_UNKNOWN;
			end
		end else if (kind == KIND_SAMPLE) begin
			parse_sample_char(ch);
		end
		if (len_cnt < MIN_SAMPLE_LEN)
			len_cnt++;
		if (!last)
			return 1'b0;

		if (len_cnt < 4'd2) begin
			r.status = ST_EMPTY;
		end else if (kind == KIND_SAMPLE) begin
			if (!bad && ph == PH_DONE && len_cnt >= MIN_SAMPLE_LEN) begin
				r.status         = ST_OK;
				r.coord_x        = fld_x;
				r.coord_y        = fld_y;
				r.level_a        = fld_a;
				r.level_b        = fld_b;
				r.flag_c         = fld_c;
				r.flag_interlock = fld_i;
				// packet counter wraps silently when it never meets the size
				next_cnt = {1'b0, in_packet} + 13'd1;
				if (next_cnt == packet_len) begin
					in_packet = '0;
					r.packet_end = 1'b1;
				end else begin
					in_packet = next_cnt[11:0];
				end
			end else begin
				r.status = ST_BAD;
			end
		end else if (kind == ST_FLUSH) begin
			r.status = ST_FLUSH;
			r.pending_count = in_packet;
			in_packet = '0;
		end else begin
			r.status = kind;
		end
		clear_line();
		return 1'b1;
	endfunction

	function automatic int field_diff(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_max = DAC_MAX_RESET;
			packet_len = PACKET_SAMPLES_RESET;
			in_packet = '0;
			clear_line();
			line_results_q.delete();
			mismatches = 0;
			results_checked = 0;
			outstanding = 0;
		end else begin
			// result request: compare with the oldest prediction
			if (results.valid && results.ready) begin
				if (line_results_q.size() == 0) begin
					$error("result with no line pending: status %0d", results.status);
					mismatches++;
				end else begin
					want = line_results_q.pop_front();
					mismatches += field_diff("status", want.status, results.status);
					mismatches += field_diff("coord_x", want.coord_x, results.coord_x);
					mismatches += field_diff("coord_y", want.coord_y, results.coord_y);
					mismatches += field_diff("level_a", want.level_a, results.level_a);
					mismatches += field_diff("level_b", want.level_b, results.level_b);
					mismatches += field_diff("flag_c", want.flag_c, results.flag_c);
					mismatches += field_diff("flag_interlock", want.flag_interlock,
						results.flag_interlock);
					mismatches += field_diff("packet_end", want.packet_end,
						results.packet_end);
					mismatches += field_diff("pending_count", want.pending_count,
						results.pending_count);
					results_checked++;
				end
			end

			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_DAC_MAX:        dac_max = pwdata[15:0];
					ADDR_PACKET_SAMPLES: packet_len = pwdata[12:0];
					default: ;
				endcase
			end

			// character request
			if (chars.valid && chars.ready) begin
				if (predict_char(chars.char_code, chars.line_end, predicted))
					line_results_q.push_back(predicted);
			end
			outstanding = line_results_q.size();
		end
	end

endmodule

// ===== verif/text_sample_line_parser_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for text_sample_line_parser: drives command lines, the APB port
// and the result stalls, and reports the verdict from tslp_line_checker.
// Depends on tslp_pkg, tslp_tb_pkg, tslp_if, tslp_line_checker and the block.
module text_sample_line_parser_tb;
	import tslp_pkg::*;
	import tslp_tb_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int STALL_LIMIT     = 2000;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int LONG_HOLD       = 300;
	localparam int HOLD_PHASE      = 1;
	localparam int PAUSE_PHASE     = 3;
	localparam int DRAIN_CYCLES    = 4;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatch_count;
	int outstanding;
	int results_checked;

	// shared between stimulus and receiver
	logic        in_idle;
	logic        out_idle;
	int          hold_request;

	logic [7:0]  line_buf[$];
	logic [15:0] cur_dac;
	int          lines_sent;
	int          chars_sent;

	tslp_char_if   in_chan();
	tslp_result_if out_chan();

	text_sample_line_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

	tslp_line_checker line_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.chars           (in_chan),
		.results         (out_chan),
		.mismatches      (mismatch_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_num(input int unsigned v, input int lead);
		logic [7:0] digs[$];
		repeat (lead) line_buf.push_back(CH_ZERO);
		do begin
			digs.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[k]) line_buf.push_back(digs[k]);
	endfunction

	// Mostly in range, with the limit itself, zero and overflows mixed in
	function automatic int unsigned pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 31);
		if (sel == 0) return cur_dac;
		if (sel == 1) return 0;
		if (sel == 2) return cur_dac + 1;
		if (sel == 3) return $urandom_range(0, 999999);
		return $urandom_range(0, cur_dac);
	endfunction

	// Well-formed sample line, sometimes damaged by one edit
	function automatic void build_sample_line();
		int n;
		int pos;
		line_buf.delete();
		line_buf.push_back(CH_S);
		line_buf.push_back(CH_EQUALS);
		for (int f = 0; f < 4; f++) begin
			put_num(pick_value(), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
			line_buf.push_back(CH_COMMA);
		end
		line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
		line_buf.push_back(CH_COMMA);
		line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
		n = $urandom_range(0, 3);
		repeat (n) line_buf.push_back(rand_byte());
		if ($urandom_range(0, 3) != 0)
			line_buf.push_back(CH_NEWLINE);
		if ($urandom_range(0, 3) == 0) begin
			pos = $urandom_range(1, line_buf.size() - 1);
			case ($urandom_range(0, 3))
				0: line_buf[pos] = rand_byte();
				1: while (line_buf.size() > pos) void'(line_buf.pop_back());
				2: line_buf.delete(pos);
				default: line_buf.insert(pos, rand_byte());
			endcase
		end
	endfunction

	// Flush, comment, other, unknown and short lines
	function automatic void build_other_line();
		int n;
		line_buf.delete();
		case ($urandom_range(0, 7))
			0, 1: line_buf.push_back(CH_F);
			2: line_buf.push_back(CH_HASH);
			3: line_buf.push_back(CH_R);
			4: line_buf.push_back(CH_E);
			5: line_buf.push_back(CH_P);
			6: line_buf.push_back(CH_S);
			default: line_buf.push_back(rand_byte());
		endcase
		n = $urandom_range(0, 5);
		repeat (n) line_buf.push_back(rand_byte());
		if ($urandom_range(0, 1) != 0)
			line_buf.push_back(CH_NEWLINE);
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic last);
		int gap;
		gap = in_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_chan.valid <= 1'b1;
		in_chan.char_code <= ch;
		in_chan.line_end <= last;
		do @(posedge clk); while (!in_chan.ready);
	endtask

	task automatic send_line();
		foreach (line_buf[k])
			send_char(line_buf[k], k == line_buf.size() - 1);
		lines_sent++;
		chars_sent += line_buf.size();
	endtask

	task automatic send_text(input string txt);
		line_buf.delete();
		for (int k = 0; k < txt.len(); k++) line_buf.push_back(txt[k]);
		send_line();
	endtask

	task automatic apb_write(input reg_addr_t addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stop offering, wait for every predicted result, then let the pipeline settle
	task automatic wait_results_drained();
		in_chan.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result receiver: random stalls, plus one long hold on request
	initial begin : receiver
		int gap;
		out_chan.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				gap = hold_request;
				hold_request = 0;
			end else begin
				gap = out_idle ? $urandom_range(0, 4) : 0;
			end
			if (gap > 0) begin
				out_chan.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_chan.ready <= 1'b1;
			do @(posedge clk); while (!out_chan.valid);
		end
	end

	// Watchdog: too long without any request or register access
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("** text_sample_line_parser: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int phase_items;
		int line_no;
		logic [15:0] next_dac;
		logic [12:0] next_pkt;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_chan.valid <= 1'b0;
		in_chan.char_code <= '0;
		in_chan.line_end <= 1'b0;
		in_idle = 1'b1;
		out_idle = 1'b1;
		hold_request = 0;
		lines_sent = 0;
		chars_sent = 0;
		cur_dac = DAC_MAX_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines at reset settings
		send_text("s=0,0,0,0,0,0\n");
		send_text("s=4095,4095,4095,4095,1,1\n");
		send_text("s=1,2,3,4,0,1");
		send_text("s=4096,1,1,1,0,0\n");
		send_text("s=1,2,3\n");
		send_text("s:1,2,3,4,0,0\n");
		send_text("s=1,,3,4,0,0\n");
		send_text("s=1,2,3,4,2,0\n");
		send_text("s=1,2,3,4,0;1\n");
		send_text("s=1,2,3,4,0,1xyz\n");
		send_text("f\n");
		send_text("# note\n");
		send_text("r\n");
		send_text("e1\n");
		send_text("p0\n");
		send_text("x\n");
		send_text("\n");
		send_text("s");
		send_text("f\n");
		line_buf.delete();
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h00);
		line_buf.push_back(8'h80);
		line_buf.push_back(CH_NEWLINE);
		send_line();
		wait_results_drained();

		// Random lines over several register settings
		for (int s = 0; s < NUM_PHASES; s++) begin
			case (s)
				0: begin
					next_dac = 16'd0;
					next_pkt = 13'd1;
				end
				1: begin
					next_dac = 16'd65535;
					next_pkt = 13'd4096;
				end
				2: begin
					next_dac = 16'd65535;
					next_pkt = 13'd0;
				end
				3: begin
					next_dac = 16'd9;
					next_pkt = 13'd2;
				end
				4: begin
					next_dac = 16'd1000;
					next_pkt = 13'd5;
				end
				default: begin
					next_dac = 16'($urandom_range(0, 65535));
					next_pkt = 13'($urandom_range(1, 16));
				end
			endcase
			apb_write(ADDR_DAC_MAX, {16'($urandom), next_dac});
			apb_write(ADDR_PACKET_SAMPLES, {19'($urandom), next_pkt});
			cur_dac = next_dac;
			in_idle = (s != 0) && ($urandom_range(0, 3) != 0);
			out_idle = (s != 0) && ($urandom_range(0, 3) != 0);

			phase_items = 0;
			line_no = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				if (s == HOLD_PHASE && line_no == 3)
					hold_request = LONG_HOLD;
				if (s == PAUSE_PHASE && line_no == 6)
					wait_results_drained();
				if ($urandom_range(0, 3) != 0)
					build_sample_line();
				else
					build_other_line();
				phase_items += line_buf.size();
				send_line();
				line_no++;
			end
			wait_results_drained();
		end

		wait_results_drained();

		$display("Run: %0d lines of %0d characters sent, %0d line results checked",
			lines_sent, chars_sent, results_checked);
		$display("Covered %0d register settings, a %0d-cycle output hold and a drain pause",
			NUM_PHASES + 1, LONG_HOLD);
		if (mismatch_count == 0)
			$display("** text_sample_line_parser: PASSED **");
		else
			$display("** text_sample_line_parser: FAILED **");
		$finish;
	end

endmodule
